// File: hdl/assert_macros.svh
// Concurrent check helpers, sampled on clk_i and idle during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

// File: hdl/rso_pkg.sv
package rso_pkg;

  localparam int unsigned DebounceW = 16;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [DebounceW-1:0] DebounceReset = DebounceW'(20);
  localparam logic [1:0]           FlipLimit     = 2'd2;
  localparam logic [1:0]           FlipMax       = 2'd3;

  localparam logic CFG_DEBOUNCE   = 1'b0;
  localparam logic CFG_ACTIVE_LOW = 1'b1;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_MODE   = 2'd1,
    CMD_ENABLE = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_AUTO = 2'd0,
    MODE_ON   = 2'd1,
    MODE_OFF  = 2'd2
  } mode_e;

  typedef struct packed {
    logic                 enabled;
    mode_e                mode;
    logic                 last_switch;
    logic                 last_light;
    logic [DebounceW-1:0] stable_ticks;
    logic                 settle_pending;
    logic [1:0]           flip_count;
    logic                 device_on;
    logic                 bypass_on;
  } state_t;

  typedef struct packed {
    logic  device_relay;
    logic  bypass_relay;
    mode_e mode_now;
    logic  module_enabled;
    logic  notify;
  } result_t;

endpackage

// File: hdl/rso_step.sv
module rso_step (
  input  rso_pkg::state_t                 state_i,
  input  logic [1:0]                      command_i,
  input  logic                            switch_level_i,
  input  logic [1:0]                      new_mode_i,
  input  logic                            new_enable_i,
  input  logic [rso_pkg::DebounceW-1:0]   debounce_ticks_i,
  input  logic                            switch_active_low_i,
  output rso_pkg::state_t                 state_o,
  output rso_pkg::result_t                result_o
);
  import rso_pkg::*;

  logic sw;
  logic pulse;

  assign sw = switch_level_i ^ switch_active_low_i;

  always_comb begin
    state_o = state_i;
    pulse   = 1'b0;
    case (command_i)
      CMD_TICK: begin
        if (state_i.enabled) begin
          if (state_i.flip_count >= FlipLimit) begin
            state_o.mode       = MODE_AUTO;
            state_o.last_light = state_i.device_on;
            if (sw != state_i.device_on) begin
              state_o.last_switch = ~sw;
            end
            state_o.flip_count = 2'd0;
          end else if (state_i.mode == MODE_ON && !state_i.last_light) begin
            state_o.device_on  = 1'b1;
            state_o.last_light = 1'b1;
          end else if (state_i.mode == MODE_OFF && state_i.last_light) begin
            state_o.device_on  = 1'b0;
            state_o.last_light = 1'b0;
          end

          if (state_o.last_switch != sw) begin
            state_o.last_switch    = sw;
            state_o.stable_ticks   = '0;
            state_o.settle_pending = 1'b1;
          end else if (state_o.settle_pending) begin
            if (state_o.stable_ticks >= debounce_ticks_i) begin
              state_o.settle_pending = 1'b0;
              state_o.stable_ticks   = '0;
              if (sw != state_o.last_light) begin
                if (state_o.mode != MODE_AUTO) begin
                  if (state_o.flip_count != FlipMax) begin
                    state_o.flip_count = state_o.flip_count + 2'd1;
                  end
                end else begin
                  state_o.device_on  = sw;
                  state_o.last_light = sw;
                  state_o.flip_count = 2'd0;
                  pulse              = 1'b1;
                end
              end
            end else begin
              state_o.stable_ticks = state_o.stable_ticks + DebounceW'(1);
            end
          end
        end
      end
      CMD_MODE: begin
        if (new_mode_i != state_i.mode && new_mode_i inside {MODE_AUTO, MODE_ON, MODE_OFF}) begin
          if (new_mode_i == MODE_AUTO) begin
            state_o.mode       = MODE_AUTO;
            state_o.last_light = state_i.device_on;
            if (sw != state_i.device_on) begin
              state_o.last_switch = ~sw;
            end
          end else begin
            state_o.mode       = mode_e'(new_mode_i);
            state_o.last_light = state_i.device_on;
          end
        end
      end
      CMD_ENABLE: begin
        if (new_enable_i && !state_i.enabled) begin
          state_o.bypass_on = 1'b1;
          case (state_i.mode)
            MODE_AUTO: state_o.device_on = sw;
            MODE_ON:   state_o.device_on = 1'b1;
            default:   state_o.device_on = 1'b0;
          endcase
          state_o.enabled = 1'b1;
        end else if (!new_enable_i && state_i.enabled) begin
          state_o.device_on = 1'b0;
          state_o.bypass_on = 1'b0;
          state_o.enabled   = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    result_o.device_relay   = state_o.device_on;
    result_o.bypass_relay   = state_o.bypass_on;
    result_o.mode_now       = state_o.mode;
    result_o.module_enabled = state_o.enabled;
    result_o.notify         = pulse;
  end

endmodule

// File: hdl/relay_switch_override_controller_unit.sv
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid_i/in_ready_o   | command, switch_level, new_mode, new_enable
// out     | output    | out_valid_o/out_ready_i | device/bypass relay, mode_now, enabled, notify
// cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One item per cycle while the result register is not stalled; an accepted item passes
// through the input register, then the result register, with the tick/command update between them.
// Reset: module on, auto mode, bypass relay on, debounce 20 ticks, active-high switch.
// A stalled result register holds; the input register takes an item while it is empty,
// or while the result register is free or being emptied in the same cycle.
`include "assert_macros.svh"

module relay_switch_override_controller_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    command_i,
  input  logic                          switch_level_i,
  input  logic [1:0]                    new_mode_i,
  input  logic                          new_enable_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          device_relay_o,
  output logic                          bypass_relay_o,
  output logic [1:0]                    mode_now_o,
  output logic                          module_enabled_o,
  output logic                          notify_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_index_i,
  input  logic [rso_pkg::CfgDataW-1:0]  cfg_data_i
);
  import rso_pkg::*;

  logic                 in_valid_q;
  logic [1:0]           command_q;
  logic                 switch_level_q;
  logic [1:0]           new_mode_q;
  logic                 new_enable_q;
  logic                 out_valid_q;
  result_t              result_q;
  result_t              result_d;
  state_t               state_q;
  state_t               state_d;
  logic [DebounceW-1:0] debounce_ticks_q;
  logic                 switch_active_low_q;
  logic                 advance;

  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign cfg_ready_o = 1'b1;

  rso_step u_step (
    .state_i            (state_q),
    .command_i          (command_q),
    .switch_level_i     (switch_level_q),
    .new_mode_i         (new_mode_q),
    .new_enable_i       (new_enable_q),
    .debounce_ticks_i   (debounce_ticks_q),
    .switch_active_low_i(switch_active_low_q),
    .state_o            (state_d),
    .result_o           (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      command_q      <= command_i;
      switch_level_q <= switch_level_i;
      new_mode_q     <= new_mode_i;
      new_enable_q   <= new_enable_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.enabled        <= 1'b1;
      state_q.mode           <= MODE_AUTO;
      state_q.last_switch    <= 1'b0;
      state_q.last_light     <= 1'b0;
      state_q.stable_ticks   <= '0;
      state_q.settle_pending <= 1'b0;
      state_q.flip_count     <= 2'd0;
      state_q.device_on      <= 1'b0;
      state_q.bypass_on      <= 1'b1;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_ticks_q    <= DebounceReset;
      switch_active_low_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_DEBOUNCE:   debounce_ticks_q    <= cfg_data_i[DebounceW-1:0];
        CFG_ACTIVE_LOW: switch_active_low_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign device_relay_o   = result_q.device_relay;
  assign bypass_relay_o   = result_q.bypass_relay;
  assign mode_now_o       = result_q.mode_now;
  assign module_enabled_o = result_q.module_enabled;
  assign notify_o         = result_q.notify;

  `ASSERT_CLK(a_notify_auto,
              out_valid_q && result_q.notify |->
                result_q.mode_now == MODE_AUTO && result_q.module_enabled,
              "notify outside auto mode")
  `ASSERT_CLK(a_off_relays,
              out_valid_q && !result_q.module_enabled |->
                !result_q.device_relay && !result_q.bypass_relay,
              "relay driven while module off")
  `ASSERT_NEVER(a_flip_bound, state_q.flip_count == FlipMax, "flip count passed return limit")
  `ASSERT_CLK(a_advance, in_valid_q && !out_valid_q |=> out_valid_q,
              "item not moved to result register")

endmodule

// File: verif/tb_relay_switch_override_controller_unit.sv
`timescale 1ns / 100ps

module tb_relay_switch_override_controller_unit;
  import rso_pkg::*;

  localparam logic [1:0] CMD_UNKNOWN    = 2'd3;
  localparam logic [1:0] MODE_BAD       = 2'd3;
  localparam int         WATCHDOG_LIMIT = 4000;
  localparam int         HOLD_CYCLES    = 64;
  localparam int         MAX_REPORTS    = 10;

  typedef struct packed {
    logic [1:0] cmd;
    logic       sw;
    logic [1:0] mode;
    logic       en;
  } relay_item_t;

  logic                clk_i            = 1'b0;
  logic                rst_ni           = 1'b0;
  logic                in_valid_i       = 1'b0;
  logic                in_ready_o;
  logic [1:0]          command_i        = '0;
  logic                switch_level_i   = 1'b0;
  logic [1:0]          new_mode_i       = '0;
  logic                new_enable_i     = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i      = 1'b0;
  logic                device_relay_o;
  logic                bypass_relay_o;
  logic [1:0]          mode_now_o;
  logic                module_enabled_o;
  logic                notify_o;
  logic                cfg_valid_i      = 1'b0;
  logic                cfg_ready_o;
  logic                cfg_index_i      = 1'b0;
  logic [CfgDataW-1:0] cfg_data_i       = '0;

  relay_item_t relay_backlog[$];
  result_t     relay_due[$];

  logic [DebounceW-1:0] pred_debounce;
  logic                 pred_active_low;
  logic                 pred_enabled;
  mode_e                pred_mode;
  logic                 pred_last_sw;
  logic                 pred_last_light;
  logic [DebounceW-1:0] pred_stable;
  logic                 pred_settle;
  logic [1:0]           pred_flips;
  logic                 pred_device;
  logic                 pred_bypass;

  int   send_idle_pct  = 28;
  int   recv_idle_pct  = 86;
  int   mismatch_count = 0;
  int   idle_cycles    = 0;
  int   hold_left      = 0;
  int   run_left       = 0;
  logic held_raw       = 1'b0;
  logic pressure_armed = 1'b0;
  logic pressure_done  = 1'b0;

  relay_switch_override_controller_unit uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .command_i        (command_i),
    .switch_level_i   (switch_level_i),
    .new_mode_i       (new_mode_i),
    .new_enable_i     (new_enable_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .device_relay_o   (device_relay_o),
    .bypass_relay_o   (bypass_relay_o),
    .mode_now_o       (mode_now_o),
    .module_enabled_o (module_enabled_o),
    .notify_o         (notify_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  function automatic void enter_auto_mode(logic sw);
    pred_mode = MODE_AUTO;
    pred_last_light = pred_device;
    if (sw != pred_last_light) pred_last_sw = ~sw;
  endfunction

  function automatic result_t predict_relays(relay_item_t it);
    logic    sw;
    logic    pulse;
    result_t r;
    sw = it.sw ^ pred_active_low;
    pulse = 1'b0;
    case (it.cmd)
      CMD_TICK: begin
        if (pred_enabled) begin
          if (pred_flips >= FlipLimit) begin
            enter_auto_mode(sw);
            pred_flips = '0;
          end else if (pred_mode == MODE_ON && !pred_last_light) begin
            pred_device = 1'b1;
            pred_last_light = 1'b1;
          end else if (pred_mode == MODE_OFF && pred_last_light) begin
            pred_device = 1'b0;
            pred_last_light = 1'b0;
          end
          if (pred_last_sw != sw) begin
            pred_last_sw = sw;
            pred_stable = '0;
            pred_settle = 1'b1;
          end else if (pred_settle) begin
            if (pred_stable >= pred_debounce) begin
              pred_settle = 1'b0;
              pred_stable = '0;
              if (sw != pred_last_light) begin
                if (pred_mode != MODE_AUTO) begin
                  if (pred_flips < FlipMax) pred_flips = pred_flips + 2'd1;
                end else begin
                  pred_device = sw;
                  pred_last_light = sw;
                  pulse = 1'b1;
                  pred_flips = '0;
                end
              end
            end else begin
              pred_stable = pred_stable + DebounceW'(1);
            end
          end
        end
      end
      CMD_MODE: begin
        if (it.mode != pred_mode && it.mode != MODE_BAD) begin
          if (it.mode == MODE_AUTO) begin
            enter_auto_mode(sw);
          end else begin
            pred_mode = mode_e'(it.mode);
            pred_last_light = pred_device;
          end
        end
      end
      CMD_ENABLE: begin
        if (it.en && !pred_enabled) begin
          pred_bypass = 1'b1;
          if (pred_mode == MODE_AUTO) pred_device = sw;
          else pred_device = (pred_mode == MODE_ON);
          pred_enabled = 1'b1;
        end else if (!it.en && pred_enabled) begin
          pred_device = 1'b0;
          pred_bypass = 1'b0;
          pred_enabled = 1'b0;
        end
      end
      default: ;
    endcase
    r.device_relay   = pred_device;
    r.bypass_relay   = pred_bypass;
    r.mode_now       = pred_mode;
    r.module_enabled = pred_enabled;
    r.notify         = pulse;
    return r;
  endfunction

  always @(posedge clk_i) begin : driver
    relay_item_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        relay_due.push_back(predict_relays({command_i, switch_level_i, new_mode_i,
                                            new_enable_i}));
      end
      if (!in_valid_i || in_ready_o) begin
        if (relay_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = relay_backlog.pop_front();
          command_i      <= nxt.cmd;
          switch_level_i <= nxt.sw;
          new_mode_i     <= nxt.mode;
          new_enable_i   <= nxt.en;
          in_valid_i     <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    result_t got;
    result_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        got = {device_relay_o, bypass_relay_o, mode_now_o, module_enabled_o, notify_o};
        if (relay_due.size() == 0) begin
          if (mismatch_count < MAX_REPORTS)
            $display("unexpected result: dev %0b byp %0b mode %0d en %0b ntf %0b",
                     got.device_relay, got.bypass_relay, got.mode_now,
                     got.module_enabled, got.notify);
          mismatch_count++;
        end else begin
          want = relay_due.pop_front();
          if (got.device_relay !== want.device_relay ||
              got.bypass_relay !== want.bypass_relay ||
              got.mode_now !== want.mode_now ||
              got.module_enabled !== want.module_enabled ||
              got.notify !== want.notify) begin
            if (mismatch_count < MAX_REPORTS)
              $display({"mismatch: expected dev %0b byp %0b mode %0d en %0b ntf %0b,",
                        " got dev %0b byp %0b mode %0d en %0b ntf %0b"},
                       want.device_relay, want.bypass_relay, want.mode_now,
                       want.module_enabled, want.notify,
                       got.device_relay, got.bypass_relay, got.mode_now,
                       got.module_enabled, got.notify);
            mismatch_count++;
          end
        end
      end
      if (pressure_armed && !pressure_done) begin
        hold_left     <= HOLD_CYCLES;
        pressure_done <= 1'b1;
        out_ready_i   <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left   <= hold_left - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_relay_switch_override_controller_unit failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic add_item(logic [1:0] cmd, logic sw, logic [1:0] mode, logic en);
    relay_backlog.push_back('{cmd: cmd, sw: sw, mode: mode, en: en});
  endtask

  task automatic settle();
    while (relay_backlog.size() != 0 || in_valid_i || relay_due.size() != 0)
      @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_DEBOUNCE) pred_debounce = data[DebounceW-1:0];
    else pred_active_low = data[0];
  endtask

  task automatic queue_random_items(int n);
    relay_item_t it;
    int          pick;
    int          cap;
    for (int k = 0; k < n; k++) begin
      it.cmd  = CMD_TICK;
      it.sw   = 1'($urandom_range(1));
      it.mode = 2'($urandom_range(3));
      it.en   = 1'($urandom_range(1));
      pick = int'($urandom_range(99));
      if (pick < 72) begin
        if (run_left == 0) begin
          held_raw = ~held_raw;
          cap = (pred_debounce > 24) ? 24 : int'(pred_debounce);
          run_left = int'($urandom_range(2 * cap + 4, 1));
        end
        run_left--;
        it.sw = held_raw;
      end else if (pick < 77) begin
        it.cmd = CMD_TICK;
      end else if (pick < 87) begin
        it.cmd  = CMD_MODE;
        it.mode = ($urandom_range(9) == 0) ? MODE_BAD : 2'($urandom_range(2));
      end else if (pick < 95) begin
        it.cmd = CMD_ENABLE;
        it.en  = ($urandom_range(9) < 8);
      end else begin
        it.cmd = CMD_UNKNOWN;
      end
      relay_backlog.push_back(it);
    end
  endtask

  task automatic run_phase(int deb, logic act_low, int n, int s_pct, int r_pct);
    settle();
    write_reg(CFG_DEBOUNCE, CfgDataW'(deb));
    write_reg(CFG_ACTIVE_LOW, CfgDataW'(act_low));
    @(negedge clk_i);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    queue_random_items(n);
  endtask

  initial begin
    pred_debounce   = DebounceReset;
    pred_active_low = 1'b0;
    pred_enabled    = 1'b1;
    pred_mode       = MODE_AUTO;
    pred_last_sw    = 1'b0;
    pred_last_light = 1'b0;
    pred_stable     = '0;
    pred_settle     = 1'b0;
    pred_flips      = '0;
    pred_device     = 1'b0;
    pred_bypass     = 1'b1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    add_item(CMD_TICK,    1'b0, MODE_BAD,  1'b1);
    add_item(CMD_UNKNOWN, 1'b1, MODE_BAD,  1'b0);
    add_item(CMD_MODE,    1'b0, MODE_BAD,  1'b1);
    add_item(CMD_MODE,    1'b1, MODE_AUTO, 1'b0);
    add_item(CMD_ENABLE,  1'b0, MODE_AUTO, 1'b1);
    add_item(CMD_MODE,    1'b1, MODE_ON,   1'b0);
    add_item(CMD_TICK,    1'b1, MODE_OFF,  1'b0);
    add_item(CMD_MODE,    1'b0, MODE_OFF,  1'b1);
    add_item(CMD_TICK,    1'b1, MODE_ON,   1'b1);
    add_item(CMD_ENABLE,  1'b1, MODE_BAD,  1'b0);
    add_item(CMD_TICK,    1'b0, MODE_AUTO, 1'b1);
    add_item(CMD_MODE,    1'b1, MODE_AUTO, 1'b1);
    add_item(CMD_ENABLE,  1'b0, MODE_ON,   1'b0);
    add_item(CMD_ENABLE,  1'b1, MODE_OFF,  1'b1);
    add_item(CMD_MODE,    1'b0, MODE_ON,   1'b0);
    add_item(CMD_ENABLE,  1'b1, MODE_AUTO, 1'b0);
    add_item(CMD_ENABLE,  1'b0, MODE_AUTO, 1'b1);
    settle();

    // inverted switch, no debounce hold: notify, then two flips back to auto
    write_reg(CFG_DEBOUNCE, 16'd0);
    write_reg(CFG_ACTIVE_LOW, CfgDataW'(1));
    @(negedge clk_i);
    add_item(CMD_MODE, 1'b1, MODE_AUTO, 1'b0);
    add_item(CMD_TICK, 1'b1, MODE_ON,   1'b0);
    add_item(CMD_TICK, 1'b1, MODE_OFF,  1'b1);
    add_item(CMD_MODE, 1'b0, MODE_OFF,  1'b0);
    add_item(CMD_TICK, 1'b0, MODE_AUTO, 1'b1);
    add_item(CMD_TICK, 1'b0, MODE_BAD,  1'b0);
    add_item(CMD_TICK, 1'b1, MODE_ON,   1'b1);
    add_item(CMD_TICK, 1'b0, MODE_AUTO, 1'b0);
    add_item(CMD_TICK, 1'b0, MODE_OFF,  1'b1);
    add_item(CMD_TICK, 1'b0, MODE_ON,   1'b0);

    run_phase(0,     1'b1, 60, 28, 86);
    run_phase(2,     1'b0, 60, 28, 86);
    run_phase(1,     1'b1, 50, 28, 86);
    run_phase(3,     1'b0, 60, 86, 28);
    run_phase(65535, 1'b1, 40, 86, 28);
    run_phase(5,     1'b0, 60, 86, 28);
    run_phase(1,     1'b1, 80, 0,  0);
    // stall the result side while items keep coming
    pressure_armed = 1'b1;
    run_phase(20,    1'b0, 90, 0,  0);

    settle();
    repeat (5) @(posedge clk_i);
    if (mismatch_count == 0 && relay_due.size() == 0) begin
      $display("tb_relay_switch_override_controller_unit passed");
    end else begin
      $display("tb_relay_switch_override_controller_unit failed");
    end
    $finish;
  end

endmodule
